// ===== hw/rtl/cmtx_pkg.sv =====
// ----------------------------------------------------------------------------
// cmtx_pkg: shared constants and types for the cube map texel address unit
// register codes, face codes, field widths and the sideband struct that
// travels down the divider chain
// ----------------------------------------------------------------------------
package cmtx_pkg;

   // default build limits
   localparam int CMTX_MAX_FACE_SIZE = 4096;
   localparam int CMTX_DIR_BITS      = 16;

   // fixed field widths
   localparam int CMTX_FACE_BITS    = 3;
   localparam int CMTX_TEXEL_BITS   = 12;
   localparam int CMTX_INDEX_BITS   = 24;
   localparam int CMTX_SIZE_BITS    = 13;
   localparam int CMTX_PRESENT_BITS = 6;
   localparam int CMTX_CSR_IDX_BITS = 2;

   // register indexes
   localparam logic [CMTX_CSR_IDX_BITS-1:0] CSR_FACE_WIDTH   = 2'd0;
   localparam logic [CMTX_CSR_IDX_BITS-1:0] CSR_FACE_HEIGHT  = 2'd1;
   localparam logic [CMTX_CSR_IDX_BITS-1:0] CSR_FACE_PRESENT = 2'd2;

   // register reset values
   localparam logic [CMTX_SIZE_BITS-1:0]    FACE_SIZE_RESET    = 13'd512;
   localparam logic [CMTX_PRESENT_BITS-1:0] FACE_PRESENT_RESET = 6'h3f;

   // face codes
   localparam logic [CMTX_FACE_BITS-1:0] FACE_RIGHT  = 3'd0;
   localparam logic [CMTX_FACE_BITS-1:0] FACE_LEFT   = 3'd1;
   localparam logic [CMTX_FACE_BITS-1:0] FACE_TOP    = 3'd2;
   localparam logic [CMTX_FACE_BITS-1:0] FACE_BOTTOM = 3'd3;
   localparam logic [CMTX_FACE_BITS-1:0] FACE_FRONT  = 3'd4;
   localparam logic [CMTX_FACE_BITS-1:0] FACE_BACK   = 3'd5;

   // per-word sideband carried alongside the divider lanes
   typedef struct packed {
      logic [CMTX_FACE_BITS-1:0] face;
      logic                      missing;
      logic                      zero_dir;
   } cmtx_side_type;

endpackage

// ===== hw/rtl/cmtx_front.sv =====
// ----------------------------------------------------------------------------
// cmtx_front: face select and numerator build
// stage a picks the major axis and face, stage b forms (size-1)*(a+n)+a
// ----------------------------------------------------------------------------
module cmtx_front
   import cmtx_pkg::*;
#(
   parameter int DIR_BITS      = CMTX_DIR_BITS,
   parameter int MAX_FACE_SIZE = CMTX_MAX_FACE_SIZE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [DIR_BITS-1:0]            dir_x,
   input  logic signed [DIR_BITS-1:0]            dir_y,
   input  logic signed [DIR_BITS-1:0]            dir_z,
   input  logic [CMTX_PRESENT_BITS-1:0]          face_present,
   input  logic [$clog2(MAX_FACE_SIZE)-1:0]      span_w,
   input  logic [$clog2(MAX_FACE_SIZE)-1:0]      span_h,
   output logic                                  out_valid,
   output cmtx_side_type                         out_side,
   output logic [DIR_BITS:0]                     out_divisor,
   output logic [$clog2(MAX_FACE_SIZE)+DIR_BITS+1:0] out_num_u,
   output logic [$clog2(MAX_FACE_SIZE)+DIR_BITS+1:0] out_num_v
);

   localparam int SB = $clog2(MAX_FACE_SIZE);
   localparam int NB = SB + DIR_BITS + 2;
   localparam int XB = DIR_BITS + 2;

   logic signed [XB-1:0]        xe, ye, ze, nu, nv, ae, su_full, sv_full;
   logic [DIR_BITS-1:0]         ax, ay, az, a_sel;
   logic [CMTX_FACE_BITS-1:0]   face_sel;
   logic                        pos_x, pos_y, pos_z;

   // stage a registers
   logic                        a_valid_ff;
   cmtx_side_type               a_side_ff, a_side_in;
   logic [DIR_BITS-1:0]         a_mag_ff;
   logic [DIR_BITS:0]           a_su_ff, a_sv_ff;

   // stage b registers
   logic                        b_valid_ff;
   cmtx_side_type               b_side_ff;
   logic [DIR_BITS:0]           b_div_ff;
   logic [NB-1:0]               b_num_u_ff, b_num_v_ff, b_num_u_in, b_num_v_in;

   always_comb begin
      xe = {{2{dir_x[DIR_BITS-1]}}, dir_x};
      ye = {{2{dir_y[DIR_BITS-1]}}, dir_y};
      ze = {{2{dir_z[DIR_BITS-1]}}, dir_z};
      ax = dir_x[DIR_BITS-1] ? DIR_BITS'(~dir_x) + DIR_BITS'(1) : dir_x;
      ay = dir_y[DIR_BITS-1] ? DIR_BITS'(~dir_y) + DIR_BITS'(1) : dir_y;
      az = dir_z[DIR_BITS-1] ? DIR_BITS'(~dir_z) + DIR_BITS'(1) : dir_z;
      // zero counts as negative
      pos_x = !dir_x[DIR_BITS-1] && (dir_x != '0);
      pos_y = !dir_y[DIR_BITS-1] && (dir_y != '0);
      pos_z = !dir_z[DIR_BITS-1] && (dir_z != '0);

      if (ax >= ay && ax >= az) begin
         a_sel = ax;
         if (pos_x) begin
            face_sel = FACE_RIGHT;
            nu       = -ze;
            nv       = -ye;
         end else begin
            face_sel = FACE_LEFT;
            nu       = ze;
            nv       = -ye;
         end
      end else if (ay >= az) begin
         a_sel = ay;
         if (pos_y) begin
            face_sel = FACE_TOP;
            nu       = xe;
            nv       = ze;
         end else begin
            face_sel = FACE_BOTTOM;
            nu       = xe;
            nv       = -ze;
         end
      end else begin
         a_sel = az;
         if (pos_z) begin
            face_sel = FACE_FRONT;
            nu       = xe;
            nv       = -ye;
         end else begin
            face_sel = FACE_BACK;
            nu       = -xe;
            nv       = -ye;
         end
      end

      ae      = {2'b00, a_sel};
      su_full = ae + nu;
      sv_full = ae + nv;

      a_side_in.face     = face_sel;
      a_side_in.missing  = !face_present[face_sel];
      a_side_in.zero_dir = (a_sel == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_side_ff <= a_side_in;
      a_mag_ff  <= a_sel;
      a_su_ff   <= su_full[DIR_BITS:0];
      a_sv_ff   <= sv_full[DIR_BITS:0];
   end

   // numerators: (size-1)*(a+n) + a
   always_comb begin
      b_num_u_in = NB'(span_w) * NB'(a_su_ff) + NB'(a_mag_ff);
      b_num_v_in = NB'(span_h) * NB'(a_sv_ff) + NB'(a_mag_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_side_ff  <= a_side_ff;
      b_div_ff   <= {a_mag_ff, 1'b0};
      b_num_u_ff <= b_num_u_in;
      b_num_v_ff <= b_num_v_in;
   end

   assign out_valid   = b_valid_ff;
   assign out_side    = b_side_ff;
   assign out_divisor = b_div_ff;
   assign out_num_u   = b_num_u_ff;
   assign out_num_v   = b_num_v_ff;

endmodule

// ===== hw/rtl/cmtx_cell.sv =====
// ----------------------------------------------------------------------------
// cmtx_cell: one restoring divide step for both coordinate lanes
// resolves quotient bit BIT_POS and hands the word to the next cell
// ----------------------------------------------------------------------------
module cmtx_cell
   import cmtx_pkg::*;
#(
   parameter int DIR_BITS      = CMTX_DIR_BITS,
   parameter int MAX_FACE_SIZE = CMTX_MAX_FACE_SIZE,
   parameter int BIT_POS       = 0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  cmtx_side_type                             in_side,
   input  logic [DIR_BITS:0]                         in_divisor,
   input  logic [$clog2(MAX_FACE_SIZE)+DIR_BITS+1:0] in_rem_u,
   input  logic [$clog2(MAX_FACE_SIZE)+DIR_BITS+1:0] in_rem_v,
   input  logic [$clog2(MAX_FACE_SIZE)-1:0]          in_quo_u,
   input  logic [$clog2(MAX_FACE_SIZE)-1:0]          in_quo_v,
   output logic                                      out_valid,
   output cmtx_side_type                             out_side,
   output logic [DIR_BITS:0]                         out_divisor,
   output logic [$clog2(MAX_FACE_SIZE)+DIR_BITS+1:0] out_rem_u,
   output logic [$clog2(MAX_FACE_SIZE)+DIR_BITS+1:0] out_rem_v,
   output logic [$clog2(MAX_FACE_SIZE)-1:0]          out_quo_u,
   output logic [$clog2(MAX_FACE_SIZE)-1:0]          out_quo_v
);

   localparam int QB = $clog2(MAX_FACE_SIZE);
   localparam int NB = QB + DIR_BITS + 2;

   logic [NB-1:0]    shifted;
   logic [NB-1:0]    rem_u_in, rem_v_in;
   logic [QB-1:0]    quo_u_in, quo_v_in;
   logic             valid_ff;
   cmtx_side_type    side_ff;
   logic [DIR_BITS:0] div_ff;
   logic [NB-1:0]    rem_u_ff, rem_v_ff;
   logic [QB-1:0]    quo_u_ff, quo_v_ff;

   always_comb begin
      shifted  = NB'(in_divisor) << BIT_POS;
      rem_u_in = in_rem_u;
      rem_v_in = in_rem_v;
      quo_u_in = in_quo_u;
      quo_v_in = in_quo_v;
      if (in_rem_u >= shifted) begin
         rem_u_in          = in_rem_u - shifted;
         quo_u_in[BIT_POS] = 1'b1;
      end
      if (in_rem_v >= shifted) begin
         rem_v_in          = in_rem_v - shifted;
         quo_v_in[BIT_POS] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff  <= in_side;
      div_ff   <= in_divisor;
      rem_u_ff <= rem_u_in;
      rem_v_ff <= rem_v_in;
      quo_u_ff <= quo_u_in;
      quo_v_ff <= quo_v_in;
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_divisor = div_ff;
   assign out_rem_u   = rem_u_ff;
   assign out_rem_v   = rem_v_ff;
   assign out_quo_u   = quo_u_ff;
   assign out_quo_v   = quo_v_ff;

endmodule

// ===== hw/rtl/cmtx_back.sv =====
// ----------------------------------------------------------------------------
// cmtx_back: coordinate finish and texel index
// applies clamp, zero-vector centre and missing-face zeroing, then row*width+col
// ----------------------------------------------------------------------------
module cmtx_back
   import cmtx_pkg::*;
#(
   parameter int MAX_FACE_SIZE = CMTX_MAX_FACE_SIZE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  cmtx_side_type                         in_side,
   input  logic [$clog2(MAX_FACE_SIZE)-1:0]      in_quo_u,
   input  logic [$clog2(MAX_FACE_SIZE)-1:0]      in_quo_v,
   input  logic [$clog2(MAX_FACE_SIZE)-1:0]      span_w,
   input  logic [$clog2(MAX_FACE_SIZE)-1:0]      span_h,
   input  logic [$clog2(MAX_FACE_SIZE+1)-1:0]    size_w,
   input  logic [$clog2(MAX_FACE_SIZE+1)-1:0]    size_h,
   output logic                                  out_strobe,
   output logic [CMTX_FACE_BITS-1:0]             out_face,
   output logic [CMTX_TEXEL_BITS-1:0]            out_texel_x,
   output logic [CMTX_TEXEL_BITS-1:0]            out_texel_y,
   output logic [CMTX_INDEX_BITS-1:0]            out_texel_index,
   output logic                                  out_face_missing
);

   localparam int QB = $clog2(MAX_FACE_SIZE);
   localparam int EB = $clog2(MAX_FACE_SIZE + 1);

   logic [QB-1:0]     tx_in, ty_in;
   logic              f_valid_ff;
   cmtx_side_type     f_side_ff;
   logic [QB-1:0]     f_tx_ff, f_ty_ff;

   logic [QB+EB-1:0]  row_base;
   logic [CMTX_INDEX_BITS-1:0] index_in;

   logic                        o_strobe_ff;
   logic [CMTX_FACE_BITS-1:0]   o_face_ff;
   logic [CMTX_TEXEL_BITS-1:0]  o_tx_ff, o_ty_ff;
   logic [CMTX_INDEX_BITS-1:0]  o_index_ff;
   logic                        o_missing_ff;

   always_comb begin
      if (in_side.missing) begin
         tx_in = '0;
         ty_in = '0;
      end else if (in_side.zero_dir) begin
         // centre of the face
         tx_in = QB'(size_w >> 1);
         ty_in = QB'(size_h >> 1);
      end else begin
         tx_in = (in_quo_u > span_w) ? span_w : in_quo_u;
         ty_in = (in_quo_v > span_h) ? span_h : in_quo_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= in_valid;
      end
      f_side_ff <= in_side;
      f_tx_ff   <= tx_in;
      f_ty_ff   <= ty_in;
   end

   always_comb begin
      row_base = (QB+EB)'(f_ty_ff) * (QB+EB)'(size_w);
      index_in = CMTX_INDEX_BITS'(row_base) + CMTX_INDEX_BITS'(f_tx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_strobe_ff <= 1'b0;
      end else begin
         o_strobe_ff <= f_valid_ff;
      end
      o_face_ff    <= f_side_ff.face;
      o_missing_ff <= f_side_ff.missing;
      o_tx_ff      <= CMTX_TEXEL_BITS'(f_tx_ff);
      o_ty_ff      <= CMTX_TEXEL_BITS'(f_ty_ff);
      o_index_ff   <= index_in;
   end

   assign out_strobe       = o_strobe_ff;
   assign out_face         = o_face_ff;
   assign out_texel_x      = o_tx_ff;
   assign out_texel_y      = o_ty_ff;
   assign out_texel_index  = o_index_ff;
   assign out_face_missing = o_missing_ff;

endmodule

// ===== hw/rtl/cube_map_texel_address.sv =====
// ----------------------------------------------------------------------------
// cube_map_texel_address: direction vector to cube face texel address
// path from start to rsp_strobe: front stages a and b, the divider cells, back stages f and o
// throughput: one word per cycle outside reset, set by the one-bit-per-cell divider chain
// reset: clears every stage valid bit and restores the size and present registers
// results are shown for one cycle under rsp_strobe; the receiver cannot stall
// ----------------------------------------------------------------------------
module cube_map_texel_address
   import cmtx_pkg::*;
#(
   parameter int MAX_FACE_SIZE = CMTX_MAX_FACE_SIZE,
   parameter int DIR_BITS      = CMTX_DIR_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic signed [DIR_BITS-1:0]       req_dir_x,
   input  logic signed [DIR_BITS-1:0]       req_dir_y,
   input  logic signed [DIR_BITS-1:0]       req_dir_z,
   // response channel
   output logic                             rsp_strobe,
   output logic [CMTX_FACE_BITS-1:0]        rsp_face,
   output logic [CMTX_TEXEL_BITS-1:0]       rsp_texel_x,
   output logic [CMTX_TEXEL_BITS-1:0]       rsp_texel_y,
   output logic [CMTX_INDEX_BITS-1:0]       rsp_texel_index,
   output logic                             rsp_face_missing,
   // register write port
   input  logic                             csr_we,
   input  logic [CMTX_CSR_IDX_BITS-1:0]     csr_index,
   input  logic [CMTX_SIZE_BITS-1:0]        csr_wdata
);

   localparam int QB = $clog2(MAX_FACE_SIZE);         // quotient bits, one cell each
   localparam int EB = $clog2(MAX_FACE_SIZE + 1);     // effective size bits
   localparam int NB = QB + DIR_BITS + 2;             // numerator / remainder bits

   // configuration registers
   logic [CMTX_SIZE_BITS-1:0]    face_width_ff, face_height_ff;
   logic [CMTX_PRESENT_BITS-1:0] face_present_ff;

   // effective sizes and size-1 spans
   logic [EB-1:0] size_w, size_h;
   logic [QB-1:0] span_w, span_h;

   // divider chain links, entry i feeds cell i
   logic                 link_valid [QB+1];
   cmtx_side_type        link_side  [QB+1];
   logic [DIR_BITS:0]    link_div   [QB+1];
   logic [NB-1:0]        link_rem_u [QB+1];
   logic [NB-1:0]        link_rem_v [QB+1];
   logic [QB-1:0]        link_quo_u [QB+1];
   logic [QB-1:0]        link_quo_v [QB+1];

   // no internal backpressure: a word is taken every cycle outside reset
   assign busy = reset;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         face_width_ff   <= FACE_SIZE_RESET;
         face_height_ff  <= FACE_SIZE_RESET;
         face_present_ff <= FACE_PRESENT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FACE_WIDTH: begin
               face_width_ff <= csr_wdata;
            end
            CSR_FACE_HEIGHT: begin
               face_height_ff <= csr_wdata;
            end
            CSR_FACE_PRESENT: begin
               face_present_ff <= csr_wdata[CMTX_PRESENT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // zero size acts as 1, oversize saturates to the build limit
   always_comb begin
      if (face_width_ff == '0) begin
         size_w = EB'(1);
      end else if (32'(face_width_ff) > MAX_FACE_SIZE) begin
         size_w = EB'(MAX_FACE_SIZE);
      end else begin
         size_w = EB'(face_width_ff);
      end
      if (face_height_ff == '0) begin
         size_h = EB'(1);
      end else if (32'(face_height_ff) > MAX_FACE_SIZE) begin
         size_h = EB'(MAX_FACE_SIZE);
      end else begin
         size_h = EB'(face_height_ff);
      end
      span_w = QB'(size_w - EB'(1));
      span_h = QB'(size_h - EB'(1));
   end

   // face select, projection and numerator multiply
   cmtx_front #(
      .DIR_BITS      (DIR_BITS),
      .MAX_FACE_SIZE (MAX_FACE_SIZE)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .dir_x        (req_dir_x),
      .dir_y        (req_dir_y),
      .dir_z        (req_dir_z),
      .face_present (face_present_ff),
      .span_w       (span_w),
      .span_h       (span_h),
      .out_valid    (link_valid[0]),
      .out_side     (link_side[0]),
      .out_divisor  (link_div[0]),
      .out_num_u    (link_rem_u[0]),
      .out_num_v    (link_rem_v[0])
   );

   // quotient starts empty, bits fill in from the top down the chain
   assign link_quo_u[0] = '0;
   assign link_quo_v[0] = '0;

   // divider chain: cell i settles quotient bit QB-1-i against 2a
   for (genvar i = 0; i < QB; i++) begin : g_cell
      cmtx_cell #(
         .DIR_BITS      (DIR_BITS),
         .MAX_FACE_SIZE (MAX_FACE_SIZE),
         .BIT_POS       (QB - 1 - i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (link_valid[i]),
         .in_side     (link_side[i]),
         .in_divisor  (link_div[i]),
         .in_rem_u    (link_rem_u[i]),
         .in_rem_v    (link_rem_v[i]),
         .in_quo_u    (link_quo_u[i]),
         .in_quo_v    (link_quo_v[i]),
         .out_valid   (link_valid[i+1]),
         .out_side    (link_side[i+1]),
         .out_divisor (link_div[i+1]),
         .out_rem_u   (link_rem_u[i+1]),
         .out_rem_v   (link_rem_v[i+1]),
         .out_quo_u   (link_quo_u[i+1]),
         .out_quo_v   (link_quo_v[i+1])
      );
   end

   // finish coordinates, form the row-major index and drive the response word
   cmtx_back #(
      .MAX_FACE_SIZE (MAX_FACE_SIZE)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (link_valid[QB]),
      .in_side          (link_side[QB]),
      .in_quo_u         (link_quo_u[QB]),
      .in_quo_v         (link_quo_v[QB]),
      .span_w           (span_w),
      .span_h           (span_h),
      .size_w           (size_w),
      .size_h           (size_h),
      .out_strobe       (rsp_strobe),
      .out_face         (rsp_face),
      .out_texel_x      (rsp_texel_x),
      .out_texel_y      (rsp_texel_y),
      .out_texel_index  (rsp_texel_index),
      .out_face_missing (rsp_face_missing)
   );

   // final remainders and divisor are not needed past the chain
   logic unused_tail;
   assign unused_tail = ^{link_div[QB], link_rem_u[QB], link_rem_v[QB]};

endmodule

// ===== tb/tb_cube_map_texel_address.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cube_map_texel_address: self-checking bench for the texel address unit
// direction words go in on the start/busy handshake and every word is
// predicted in a small scoreboard (face pick, projection, rounding, index,
// missing flag). results arrive under rsp_strobe and are compared in order.
// a directed set opens the run, then random words under several register
// settings, with random gaps on the request side
// ----------------------------------------------------------------------------

import cmtx_pkg::*;

typedef struct {
   logic [CMTX_FACE_BITS-1:0]  face;
   logic [CMTX_TEXEL_BITS-1:0] texel_x;
   logic [CMTX_TEXEL_BITS-1:0] texel_y;
   logic [CMTX_INDEX_BITS-1:0] texel_index;
   logic                       missing;
} texel_word_type;

class texel_scoreboard;
   texel_word_type                 pending_texels[$];
   logic [CMTX_SIZE_BITS-1:0]      width_reg;
   logic [CMTX_SIZE_BITS-1:0]      height_reg;
   logic [CMTX_PRESENT_BITS-1:0]   present_reg;
   int unsigned                    errors;

   function new();
      width_reg   = FACE_SIZE_RESET;
      height_reg  = FACE_SIZE_RESET;
      present_reg = FACE_PRESENT_RESET;
      errors      = 0;
   endfunction

   function void write_register(logic [CMTX_CSR_IDX_BITS-1:0] idx,
                                logic [CMTX_SIZE_BITS-1:0] data);
      case (idx)
         CSR_FACE_WIDTH:   width_reg = data;
         CSR_FACE_HEIGHT:  height_reg = data;
         CSR_FACE_PRESENT: present_reg = data[CMTX_PRESENT_BITS-1:0];
         default: ;
      endcase
   endfunction

   // zero reads as one, anything past the build limit saturates
   function int unsigned usable_size(logic [CMTX_SIZE_BITS-1:0] raw);
      if (raw == 0) return 1;
      if (raw > CMTX_MAX_FACE_SIZE) return CMTX_MAX_FACE_SIZE;
      return 32'(raw);
   endfunction

   // round(s*(a+n)/(2a)), halves up, with the centre for a zero major axis
   function longint unsigned project(int unsigned size, longint a, longint n);
      longint unsigned s;
      longint unsigned num;
      longint unsigned q;
      s = size - 1;
      if (a == 0) return (s + 1) / 2;
      num = s * longint'(a + n) + a;
      q = num / (2 * a);
      if (q > s) q = s;
      return q;
   endfunction

   function void note_direction(logic signed [15:0] dx, logic signed [15:0] dy,
                                logic signed [15:0] dz);
      longint x, y, z, ax, ay, az, a, nu, nv;
      longint unsigned tx, ty;
      int unsigned w, h;
      texel_word_type t;
      x = dx;
      y = dy;
      z = dz;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      w = usable_size(width_reg);
      h = usable_size(height_reg);
      if (ax >= ay && ax >= az) begin
         a = ax;
         if (x > 0) begin
            t.face = FACE_RIGHT;  nu = -z; nv = -y;
         end else begin
            t.face = FACE_LEFT;   nu = z;  nv = -y;
         end
      end else if (ay >= az) begin
         a = ay;
         if (y > 0) begin
            t.face = FACE_TOP;    nu = x;  nv = z;
         end else begin
            t.face = FACE_BOTTOM; nu = x;  nv = -z;
         end
      end else begin
         a = az;
         if (z > 0) begin
            t.face = FACE_FRONT;  nu = x;  nv = -y;
         end else begin
            t.face = FACE_BACK;   nu = -x; nv = -y;
         end
      end
      t.missing = !present_reg[t.face];
      if (t.missing) begin
         tx = 0;
         ty = 0;
      end else begin
         tx = project(w, a, nu);
         ty = project(h, a, nv);
      end
      t.texel_x     = tx[CMTX_TEXEL_BITS-1:0];
      t.texel_y     = ty[CMTX_TEXEL_BITS-1:0];
      t.texel_index = t.missing ? '0 : CMTX_INDEX_BITS'(ty * w + tx);
      pending_texels.push_back(t);
   endfunction

   function void check_texel(texel_word_type got);
      texel_word_type want;
      if (pending_texels.size() == 0) begin
         $error("unexpected word: face %0d x %0d y %0d", got.face, got.texel_x,
                got.texel_y);
         errors++;
         return;
      end
      want = pending_texels.pop_front();
      if (got.face !== want.face) begin
         $error("face: expected %0d, got %0d", want.face, got.face);
         errors++;
      end
      if (got.texel_x !== want.texel_x) begin
         $error("texel_x: expected %0d, got %0d", want.texel_x, got.texel_x);
         errors++;
      end
      if (got.texel_y !== want.texel_y) begin
         $error("texel_y: expected %0d, got %0d", want.texel_y, got.texel_y);
         errors++;
      end
      if (got.texel_index !== want.texel_index) begin
         $error("texel_index: expected %0d, got %0d", want.texel_index,
                got.texel_index);
         errors++;
      end
      if (got.missing !== want.missing) begin
         $error("face_missing: expected %0d, got %0d", want.missing, got.missing);
         errors++;
      end
   endfunction

   function int pending();
      return pending_texels.size();
   endfunction
endclass

module tb_cube_map_texel_address;

   // pipeline depth of the block: front stages, divider cells and back stages
   localparam int LATENCY        = $clog2(CMTX_MAX_FACE_SIZE) + 4;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 8;
   localparam int WORDS_PER_PHASE = 250;
   localparam int DIRECTED_WORDS = 18;
   // the one index the block does not decode
   localparam logic [CMTX_CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [15:0]            req_dir_x;
   logic signed [15:0]            req_dir_y;
   logic signed [15:0]            req_dir_z;
   logic                          rsp_strobe;
   logic [CMTX_FACE_BITS-1:0]     rsp_face;
   logic [CMTX_TEXEL_BITS-1:0]    rsp_texel_x;
   logic [CMTX_TEXEL_BITS-1:0]    rsp_texel_y;
   logic [CMTX_INDEX_BITS-1:0]    rsp_texel_index;
   logic                          rsp_face_missing;
   logic                          csr_we;
   logic [CMTX_CSR_IDX_BITS-1:0]  csr_index;
   logic [CMTX_SIZE_BITS-1:0]     csr_wdata;

   texel_scoreboard sb = new();

   // run length of back-to-back words still owed by the gap picker
   int burst_left = 0;
   int idle_cycles = 0;

   logic signed [15:0] directed_dirs [0:DIRECTED_WORDS-1][0:2];

   cube_map_texel_address u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_dir_x        (req_dir_x),
      .req_dir_y        (req_dir_y),
      .req_dir_z        (req_dir_z),
      .rsp_strobe       (rsp_strobe),
      .rsp_face         (rsp_face),
      .rsp_texel_x      (rsp_texel_x),
      .rsp_texel_y      (rsp_texel_y),
      .rsp_texel_index  (rsp_texel_index),
      .rsp_face_missing (rsp_face_missing),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: the receiver never stalls, so every strobe is a word
   always @(posedge clock) begin
      texel_word_type got;
      if (!reset && rsp_strobe) begin
         got.face        = rsp_face;
         got.texel_x     = rsp_texel_x;
         got.texel_y     = rsp_texel_y;
         got.texel_index = rsp_texel_index;
         got.missing     = rsp_face_missing;
         sb.check_texel(got);
      end
   end

   // watchdog: any cycle with neither a request nor a result taken counts
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // mostly back to back or short gaps, now and then a long pause,
   // plus bursts with no gap at all
   function automatic int draw_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(16, 60);
   endfunction

   // random sign on a magnitude that fits in 15 bits
   function automatic logic signed [15:0] signed_of(int unsigned mag);
      logic signed [15:0] v;
      v = 16'(mag);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   // value no larger in magnitude than the major axis
   function automatic logic signed [15:0] minor_of(int unsigned mag);
      return signed_of($urandom_range(0, mag));
   endfunction

   task automatic draw_direction(output logic signed [15:0] x,
                                 output logic signed [15:0] y,
                                 output logic signed [15:0] z);
      int mode;
      int unsigned m;
      int axis;
      logic signed [15:0] edges [0:5];
      logic signed [15:0] v [0:2];
      edges = '{-32768, 32767, 0, -1, 1, -32767};
      mode = $urandom_range(0, 9);
      axis = $urandom_range(0, 2);
      case (mode)
         0, 1, 2: begin
            // raw bit patterns
            v[0] = 16'($urandom);
            v[1] = 16'($urandom);
            v[2] = 16'($urandom);
         end
         3: begin
            // tiny vectors where rounding halves show up
            m = $urandom_range(0, 8);
            v[0] = minor_of(m);
            v[1] = minor_of(m);
            v[2] = minor_of(m);
            v[axis] = signed_of(m);
         end
         4: begin
            // two axes tied in magnitude
            m = $urandom_range(0, 32767);
            v[0] = signed_of(m);
            v[1] = signed_of(m);
            v[2] = signed_of(m);
            v[axis] = minor_of(m);
         end
         5, 6: begin
            // one clear major axis, minors anywhere inside it
            m = $urandom_range(1, 32767);
            v[0] = minor_of(m);
            v[1] = minor_of(m);
            v[2] = minor_of(m);
            v[axis] = signed_of(m);
         end
         7: begin
            // one minor pinned to a face edge, the other random inside it
            m = $urandom_range(0, 32767);
            v[0] = signed_of(m);
            v[1] = signed_of(m);
            v[2] = signed_of(m);
            v[axis] = signed_of(m);
            v[(axis + 1) % 3] = minor_of(m);
         end
         default: begin
            v[0] = edges[$urandom_range(0, 5)];
            v[1] = edges[$urandom_range(0, 5)];
            v[2] = edges[$urandom_range(0, 5)];
         end
      endcase
      x = v[0];
      y = v[1];
      z = v[2];
   endtask

   // word held on the request ports until the block takes it
   task automatic send_direction(logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z);
      @(negedge clock);
      start     <= 1'b1;
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_direction(x, y, z);
   endtask

   task automatic hold_off(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // drop start and wait for every outstanding word
   task automatic drain_texels();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CMTX_CSR_IDX_BITS-1:0] idx,
                            logic [CMTX_SIZE_BITS-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   function automatic logic [CMTX_SIZE_BITS-1:0] draw_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return CMTX_SIZE_BITS'($urandom_range(1, 64));
      if (r < 85) return CMTX_SIZE_BITS'($urandom_range(1, CMTX_MAX_FACE_SIZE));
      return CMTX_SIZE_BITS'($urandom);
   endfunction

   initial begin
      logic signed [15:0] dx, dy, dz;
      logic [CMTX_SIZE_BITS-1:0] w, h, p;

      // every input known from time zero
      reset     = 1'b1;
      start     = 1'b0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_dir_z = '0;
      csr_we    = 1'b0;
      csr_index = CSR_FACE_WIDTH;
      csr_wdata = '0;

      directed_dirs = '{
         '{0, 0, 0},                    // zero vector, centre of left face
         '{32767, 0, 0},
         '{-32768, 0, 0},
         '{0, 32767, 0},
         '{0, -32768, 0},
         '{0, 0, 32767},
         '{0, 0, -32768},
         '{1000, -1000, 5},             // x and y tied, x wins
         '{3, -2000, 2000},             // y and z tied, y wins
         '{-32768, -32768, -32768},     // three-way tie at the most negative
         '{32767, 32767, 32767},
         '{32767, -32767, 32767},       // minors at opposite face edges
         '{100, -100, -100},
         '{1, 0, 0},
         '{-1, 1, -1},
         '{0, 0, -1},
         '{5, 3, -5},                   // x and z tied
         '{-32768, 32767, -32767}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words under the reset register values
      for (int i = 0; i < DIRECTED_WORDS; i++) begin
         send_direction(directed_dirs[i][0], directed_dirs[i][1], directed_dirs[i][2]);
         hold_off(draw_gap());
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         // registers change only with the pipe empty
         drain_texels();
         repeat (LATENCY) @(posedge clock);
         case (ph)
            0: begin
               w = CMTX_SIZE_BITS'(CMTX_MAX_FACE_SIZE);
               h = CMTX_SIZE_BITS'(CMTX_MAX_FACE_SIZE);
               p = 13'h3f;
            end
            1: begin w = 13'd0;              h = 13'h1fff;           p = 13'h1fc0; end
            2: begin w = 13'd1;              h = 13'd1;              p = 13'h2a;   end
            3: begin
               w = CMTX_SIZE_BITS'(CMTX_MAX_FACE_SIZE + 1);
               h = 13'd2;
               p = 13'h15;
            end
            default: begin
               w = draw_size();
               h = draw_size();
               p = CMTX_SIZE_BITS'($urandom);
            end
         endcase
         write_csr(CSR_FACE_WIDTH, w);
         write_csr(CSR_FACE_HEIGHT, h);
         write_csr(CSR_FACE_PRESENT, p);
         // undecoded index must leave the registers alone
         write_csr(CSR_SPARE, CMTX_SIZE_BITS'($urandom));
         @(negedge clock);
         csr_we <= 1'b0;

         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            draw_direction(dx, dy, dz);
            send_direction(dx, dy, dz);
            if ($urandom_range(0, 149) == 0) drain_texels();
            else hold_off(draw_gap());
         end
      end

      drain_texels();
      repeat (LATENCY + 4) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (sb.pending() != 0) $error("%0d words never came back", sb.pending());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
